// ----- rtl/core/ptp_offset_delay_pi_servo_assert.svh -----
`ifndef PTP_OFFSET_DELAY_PI_SERVO_ASSERT_SVH
`define PTP_OFFSET_DELAY_PI_SERVO_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PODS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pods: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PODS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pods: next-cycle check failed");

`endif

// ----- rtl/core/pods_pkg.sv -----
package pods_pkg;

   localparam logic [30:0] NsPerSec   = 31'd1000000000;
   localparam int          PiAdjMax   = 1000000;
   localparam int          AdjLimit   = 501000;
   // Reciprocal of 1000 scaled by 2**40 and rounded up; exact for dividends below 2**32.
   localparam logic [30:0] RecipMult  = 31'd1099511628;
   localparam int          RecipShift = 40;

   typedef struct packed {
      logic [31:0] sec;
      logic [30:0] nsec;
   } stamp_type;

   typedef struct packed {
      logic        neg;
      logic [31:0] sec;
      logic [29:0] nsec;
   } span_type;

endpackage

// ----- rtl/core/pods_if.sv -----
interface pods_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] master_send_sec;
   logic [29:0] master_send_nsec;
   logic [31:0] slave_recv_sec;
   logic [29:0] slave_recv_nsec;
   logic [31:0] slave_send_sec;
   logic [29:0] slave_send_nsec;
   logic [31:0] master_recv_sec;
   logic [29:0] master_recv_nsec;

   modport source (
      output valid, master_send_sec, master_send_nsec, slave_recv_sec, slave_recv_nsec,
             slave_send_sec, slave_send_nsec, master_recv_sec, master_recv_nsec,
      input  ready
   );
   modport sink (
      input  valid, master_send_sec, master_send_nsec, slave_recv_sec, slave_recv_nsec,
             slave_send_sec, slave_send_nsec, master_recv_sec, master_recv_nsec,
      output ready
   );
endinterface

interface pods_rsp_if;
   logic               valid;
   logic               ready;
   logic               step_needed;
   logic               offset_negative;
   logic [31:0]        offset_sec;
   logic [29:0]        offset_nsec;
   logic               delay_negative;
   logic [31:0]        delay_sec;
   logic [29:0]        delay_nsec;
   logic signed [19:0] freq_adjust;

   modport source (
      output valid, step_needed, offset_negative, offset_sec, offset_nsec,
             delay_negative, delay_sec, delay_nsec, freq_adjust,
      input  ready
   );
   modport sink (
      input  valid, step_needed, offset_negative, offset_sec, offset_nsec,
             delay_negative, delay_sec, delay_nsec, freq_adjust,
      output ready
   );
endinterface

// ----- rtl/core/ptp_offset_delay_pi_servo.sv -----
// Channel   Direction  Handshake            Word
// req_ch    in         valid/ready          four timestamps t1..t4, seconds and ns
// rsp_ch    out        valid/ready          offset, delay, step flag, frequency adjust
//
// A word passes seven registered stages, and one word can be taken in every cycle
// unless a stalled result has backed up all stages.
// Each stage loads whenever it or the stage after it is free, so a stalled result
// only stops the stages behind it once they have filled up.
// The offset filter and the integral term are updated in their own stages.
// A synchronous reset empties all stages and clears the filter and the integral.
module ptp_offset_delay_pi_servo (
   input  logic clock,
   input  logic reset,
   pods_req_if.sink   req_ch,
   pods_rsp_if.source rsp_ch
);
   import pods_pkg::*;

   localparam logic signed [27:0] IntegHi = 28'(PiAdjMax);
   localparam logic signed [27:0] IntegLo = -IntegHi;

   typedef struct packed {
      logic [3:0][31:0] sec;
      logic [3:0][29:0] nsec;
   } raw_type;

   typedef struct packed {
      stamp_type dly_late;
      stamp_type dly_early;
      stamp_type off_late;
      stamp_type off_early;
   } sums_type;

   typedef struct packed {
      span_type dly;
      span_type off;
   } spans_type;

   typedef struct packed {
      logic     step;
      span_type dly;
      span_type off;
   } filt_type;

   typedef struct packed {
      logic               step;
      span_type           dly;
      span_type           off;
      logic [28:0]        prop;
      logic signed [20:0] integ;
   } pi_type;

   typedef struct packed {
      logic        step;
      span_type    dly;
      span_type    off;
      logic        sum_neg;
      logic [29:0] mag;
   } sum_type;

   typedef struct packed {
      logic               step;
      span_type           dly;
      span_type           off;
      logic signed [19:0] freq;
   } rsp_type;

   function automatic stamp_type halve(input logic [31:0] sec, input logic [29:0] nsec);
      logic [30:0] n;
      stamp_type   r;
      n      = {1'b0, nsec} + (sec[0] ? NsPerSec : 31'd0);
      r.sec  = {1'b0, sec[31:1]};
      r.nsec = {1'b0, n[30:1]};
      return r;
   endfunction

   function automatic stamp_type add_stamp(input stamp_type a, input stamp_type b);
      logic [31:0] n;
      stamp_type   r;
      n     = {1'b0, a.nsec} + {1'b0, b.nsec};
      r.sec = a.sec + b.sec;
      if (n >= {1'b0, NsPerSec}) begin
         r.sec = r.sec + 32'd1;
         n     = n - {1'b0, NsPerSec};
      end
      r.nsec = n[30:0];
      return r;
   endfunction

   function automatic span_type sub_stamp(input stamp_type a, input stamp_type b);
      stamp_type   big;
      stamp_type   lil;
      logic        borrow;
      logic [31:0] n;
      span_type    r;
      r.neg  = (a.sec < b.sec) || ((a.sec == b.sec) && (a.nsec < b.nsec));
      big    = r.neg ? b : a;
      lil    = r.neg ? a : b;
      borrow = big.nsec < lil.nsec;
      n      = {1'b0, big.nsec} + (borrow ? {1'b0, NsPerSec} : 32'd0) - {1'b0, lil.nsec};
      r.sec  = big.sec - lil.sec - {31'd0, borrow};
      r.nsec = n[29:0];
      return r;
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en6, en_out;

   raw_type   s1_ff, s1_in;
   sums_type  s2_ff, s2_in;
   spans_type s3_ff, s3_in;
   filt_type  s4_ff, s4_in;
   pi_type    s5_ff, s5_in;
   sum_type   s6_ff, s6_in;
   rsp_type   rsp_ff, rsp_in;

   logic [29:0]        filter_ff, filter_in;
   logic signed [20:0] integral_ff, integral_in;

   stamp_type t1, t2, t3, t4;
   logic [30:0]        filt_sum;
   logic [25:0]        inc;
   logic signed [27:0] integ_wide;
   logic signed [30:0] prop_s, sum, neg_sum;
   logic [60:0]        prod;
   logic [20:0]        quot;
   logic [19:0]        quot_sat;

   assign en_out = !rsp_valid_ff || rsp_ch.ready;
   assign en6    = !v6_ff || en_out;
   assign en5    = !v5_ff || en6;
   assign en4    = !v4_ff || en5;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign req_ch.ready = en1;

   always_comb begin
      s1_in.sec[0]  = req_ch.master_send_sec;
      s1_in.nsec[0] = req_ch.master_send_nsec;
      s1_in.sec[1]  = req_ch.slave_recv_sec;
      s1_in.nsec[1] = req_ch.slave_recv_nsec;
      s1_in.sec[2]  = req_ch.slave_send_sec;
      s1_in.nsec[2] = req_ch.slave_send_nsec;
      s1_in.sec[3]  = req_ch.master_recv_sec;
      s1_in.nsec[3] = req_ch.master_recv_nsec;
   end

   always_comb begin
      t1 = halve(s1_ff.sec[0], s1_ff.nsec[0]);
      t2 = halve(s1_ff.sec[1], s1_ff.nsec[1]);
      t3 = halve(s1_ff.sec[2], s1_ff.nsec[2]);
      t4 = halve(s1_ff.sec[3], s1_ff.nsec[3]);
      s2_in.dly_late  = add_stamp(t2, t4);
      s2_in.dly_early = add_stamp(t1, t3);
      s2_in.off_late  = add_stamp(t1, t4);
      s2_in.off_early = add_stamp(t2, t3);
   end

   always_comb begin
      s3_in.dly = sub_stamp(s2_ff.dly_late, s2_ff.dly_early);
      s3_in.off = sub_stamp(s2_ff.off_late, s2_ff.off_early);
   end

   always_comb begin
      filt_sum   = {1'b0, filter_ff} + {1'b0, s3_ff.off.nsec};
      filter_in  = filt_sum[30:1];
      s4_in.step = s3_ff.off.sec != 32'd0;
      s4_in.dly  = s3_ff.dly;
      s4_in.off  = s3_ff.off;
      if (!s4_in.step) begin
         s4_in.off.nsec = filter_in;
      end
   end

   always_comb begin
      inc = s4_ff.off.nsec[29:4];
      if (s4_ff.off.neg) begin
         integ_wide = {{7{integral_ff[20]}}, integral_ff} - $signed({2'b00, inc});
         if (integ_wide < IntegLo) begin
            integ_wide = IntegLo;
         end
      end else begin
         integ_wide = {{7{integral_ff[20]}}, integral_ff} + $signed({2'b00, inc});
         if (integ_wide > IntegHi) begin
            integ_wide = IntegHi;
         end
      end
      integral_in = integ_wide[20:0];
      s5_in.step  = s4_ff.step;
      s5_in.dly   = s4_ff.dly;
      s5_in.off   = s4_ff.off;
      s5_in.prop  = s4_ff.off.nsec[29:1];
      s5_in.integ = s4_ff.step ? integral_ff : integral_in;
   end

   always_comb begin
      prop_s = s5_ff.off.neg ? -$signed({2'b00, s5_ff.prop}) : $signed({2'b00, s5_ff.prop});
      sum     = prop_s + {{10{s5_ff.integ[20]}}, s5_ff.integ};
      neg_sum = -sum;
      s6_in.step    = s5_ff.step;
      s6_in.dly     = s5_ff.dly;
      s6_in.off     = s5_ff.off;
      s6_in.sum_neg = sum[30];
      s6_in.mag     = sum[30] ? neg_sum[29:0] : sum[29:0];
   end

   always_comb begin
      prod     = {31'd0, s6_ff.mag} * {30'd0, RecipMult};
      quot     = prod[RecipShift +: 21];
      quot_sat = (quot > 21'(AdjLimit)) ? 20'(AdjLimit) : quot[19:0];
      rsp_in.step = s6_ff.step;
      rsp_in.dly  = s6_ff.dly;
      rsp_in.off  = s6_ff.off;
      if (s6_ff.step) begin
         rsp_in.freq = '0;
      end else if (s6_ff.sum_neg) begin
         rsp_in.freq = -$signed(quot_sat);
      end else begin
         rsp_in.freq = $signed(quot_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         filter_ff    <= '0;
         integral_ff  <= '0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en_out) rsp_valid_ff <= v6_ff;
         if (en4 && v3_ff && !s4_in.step) begin
            filter_ff <= filter_in;
         end
         if (en5 && v4_ff && !s4_ff.step) begin
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
      if (en5) s5_ff <= s5_in;
      if (en6) s6_ff <= s6_in;
      if (en_out) rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.step_needed     = rsp_ff.step;
   assign rsp_ch.offset_negative = rsp_ff.off.neg;
   assign rsp_ch.offset_sec      = rsp_ff.off.sec;
   assign rsp_ch.offset_nsec     = rsp_ff.off.nsec;
   assign rsp_ch.delay_negative  = rsp_ff.dly.neg;
   assign rsp_ch.delay_sec       = rsp_ff.dly.sec;
   assign rsp_ch.delay_nsec      = rsp_ff.dly.nsec;
   assign rsp_ch.freq_adjust     = rsp_ff.freq;

endmodule

// ----- rtl/core/pods_checker.sv -----
`include "ptp_offset_delay_pi_servo_assert.svh"

module pods_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               step_needed,
   input logic [31:0]        offset_sec,
   input logic [29:0]        offset_nsec,
   input logic signed [19:0] freq_adjust
);
   import pods_pkg::*;

   localparam logic signed [19:0] FreqHi = 20'(AdjLimit);
   localparam logic signed [19:0] FreqLo = -FreqHi;

   logic        sec_nonzero;
   logic        adjust_in_range;
   logic        stalled;
   logic [49:0] held_word;

   assign sec_nonzero     = offset_sec != '0;
   assign adjust_in_range = (freq_adjust <= FreqHi) && (freq_adjust >= FreqLo);
   assign stalled         = rsp_valid && !rsp_ready;
   assign held_word       = {offset_nsec, freq_adjust};

   // A step result carries no frequency correction.
   `PODS_ASSERT_SAME(a_step_no_adjust, clock, reset, rsp_valid && step_needed, freq_adjust == '0)

   // The step flag follows the offset seconds of the same word.
   `PODS_ASSERT_SAME(a_step_matches_sec, clock, reset, rsp_valid, step_needed == sec_nonzero)

   `PODS_ASSERT_SAME(a_adjust_range, clock, reset, rsp_valid, adjust_in_range)

   `PODS_ASSERT_NEXT(a_stall_holds, clock, reset, stalled, rsp_valid && $stable(held_word))

   `PODS_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

endmodule

bind ptp_offset_delay_pi_servo pods_checker u_pods_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .step_needed (rsp_ch.step_needed),
   .offset_sec  (rsp_ch.offset_sec),
   .offset_nsec (rsp_ch.offset_nsec),
   .freq_adjust (rsp_ch.freq_adjust)
);
